// File: src/afrg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrg_pkg
// Shared types and constants of the adaptive frame rate governor.
// ----------------------------------------------------------------------------
package afrg_pkg;

  localparam logic [2:0] REG_BASE = 3'd0;
  localparam logic [2:0] REG_MIN  = 3'd1;
  localparam logic [2:0] REG_MAX  = 3'd2;
  localparam logic [2:0] REG_QLIM = 3'd3;
  localparam logic [2:0] REG_LLIM = 3'd4;
  localparam logic [2:0] REG_DEC  = 3'd5;
  localparam logic [2:0] REG_INC  = 3'd6;

  localparam logic [16:0] Q16_ONE      = 17'd65536;
  localparam logic [18:0] Q16_MAXP     = 19'd262144;
  localparam logic [31:0] CPU_LIM      = 32'd58982;
  localparam logic [31:0] DROP_LIM     = 32'd3277;
  localparam logic [16:0] Q16_QUARTER  = 17'd16384;
  localparam logic [17:0] DEF_BASE     = 18'd7680;
  localparam logic [17:0] DEF_MIN      = 18'd256;
  localparam logic [17:0] DEF_QLIM     = 18'd52429;
  localparam logic [15:0] DEF_DEC      = 16'd52429;
  localparam logic [15:0] DEC_LO       = 16'd3277;
  localparam logic [15:0] DEC_HI       = 16'd64881;
  localparam logic [17:0] DEF_INC      = 18'd68813;
  localparam logic [17:0] INC_LO       = 18'd65536;
  localparam logic [17:0] INC_HI       = 18'd131072;

  // number of pressure sources and divider quotient width
  localparam int NSRC = 5;
  localparam int QW   = 19;

  typedef struct packed {
    logic load;     // capture item, start first division
    logic div_go;   // start division for the current source
    logic src_last; // current source is the last pressure source
    logic fac_go;   // start the factor division
    logic mul;      // apply the rate update
    logic commit;   // write back the rate and present the result
  } afrg_cmd_t;

  typedef struct packed {
    logic div_done;
  } afrg_sts_t;

endpackage

// File: src/afrg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrg_ctrl
// Sequencer: walks the pressure sources through the shared divider, then the
// factor division and the rate update.
// ----------------------------------------------------------------------------
module afrg_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output afrg_pkg::afrg_cmd_t  cmd,
  output logic [2:0]           src,
  input  afrg_pkg::afrg_sts_t  sts
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_NEXT = 6'b000100,
    S_FAC  = 6'b001000,
    S_MUL  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t     state, state_next;
  logic [2:0] src_next;

  // an item is taken only while idle
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    src_next      = src;
    cmd           = '0;
    cmd.src_last  = (src == 3'(afrg_pkg::NSRC - 1));
    case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load   = 1'b1;
          src_next   = '0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        if (cmd.src_last) begin
          cmd.fac_go    = 1'b1;
          state_next    = S_FAC;
        end else begin
          src_next   = src + 3'd1;
          cmd.div_go = 1'b1;
          state_next = S_DIV;
        end
      end
      S_FAC: begin
        if (sts.div_done) begin
          state_next    = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid) begin
          cmd.commit = 1'b1;
        end else if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      src       <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      src      <= src_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: src/afrg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrg_div
// Restoring divider, one quotient bit per cycle: floor(num * 2^16 / den), saturated to QW bits.
// ----------------------------------------------------------------------------
module afrg_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [31:0]                num,
  input  logic [31:0]                den,
  output logic [afrg_pkg::QW-1:0]    quo,
  output logic                       done
);

  localparam int STEPS = 48;
  localparam int CW    = $clog2(STEPS);

  logic [32:0]   rem;
  logic [31:0]   dsr;
  logic [47:0]   dvd;
  logic [CW-1:0] cnt;
  logic          run;
  logic [32:0]   trial;
  logic          sat;
  logic [afrg_pkg::QW-1:0] q_reg;

  // quotient bits above QW are only needed to detect saturation
  assign trial = {rem[31:0], dvd[47]} - {1'b0, dsr};
  assign quo   = sat ? '1 : q_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        if (cnt == CW'(STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      dvd   <= {num, 16'd0};
      dsr   <= den;
      q_reg <= '0;
      sat   <= 1'b0;
    end else if (run) begin
      dvd <= {dvd[46:0], 1'b0};
      if (q_reg[afrg_pkg::QW-1]) sat <= 1'b1;
      if (!trial[32]) begin
        rem   <= trial;
        q_reg <= {q_reg[afrg_pkg::QW-2:0], 1'b1};
      end else begin
        rem   <= {rem[31:0], dvd[47]};
        q_reg <= {q_reg[afrg_pkg::QW-2:0], 1'b0};
      end
    end
  end

endmodule

// File: src/afrg_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrg_dp
// Datapath: effective configuration, source operands, pressure maximum,
// rate multiply and clamp.
// ----------------------------------------------------------------------------
module afrg_dp #(
  parameter int RATE_WIDTH = 18
) (
  input  logic                        clk,
  input  logic                        rst,
  input  afrg_pkg::afrg_cmd_t         cmd,
  input  logic [2:0]                  src,
  output afrg_pkg::afrg_sts_t         sts,
  input  logic                        cfg_valid,
  input  logic [2:0]                  cfg_index,
  input  logic [31:0]                 cfg_data,
  input  logic signed [31:0]          latency,
  input  logic [16:0]                 queue_fill,
  input  logic [16:0]                 cpu_load,
  input  logic [16:0]                 gpu_load,
  input  logic [16:0]                 drop_rate,
  output logic [RATE_WIDTH-1:0]       target_fps,
  output logic                        overloaded
);

  localparam int RW = RATE_WIDTH;
  localparam int QW = afrg_pkg::QW;

  logic [RW-1:0] reg_base, reg_min, reg_max;
  logic [17:0]   reg_qlim;
  logic [19:0]   reg_llim;
  logic [15:0]   reg_dec;
  logic [17:0]   reg_inc;

  logic [RW-1:0] e_base, e_min, e_max, m0, b0, b1;
  logic [17:0]   e_qlim;
  logic [15:0]   e_dec, d0;
  logic [17:0]   e_inc, i0;

  logic [31:0]   lat;
  logic [16:0]   qu, cu, gu, dr;
  logic [RW-1:0] rate, rate_new;
  logic [QW-1:0] pmax, pcur;
  logic          over;
  logic [31:0]   num, den;
  logic          skip, done_q, div_start;
  logic [QW-1:0] quo;
  logic          div_done;
  logic [16:0]   factor;
  logic [RW+17:0] prod;
  logic [RW:0]   r1;
  logic [RW-1:0] r2;
  logic          init;

  function automatic logic [16:0] sat1(input logic [16:0] v);
    return (v > afrg_pkg::Q16_ONE) ? afrg_pkg::Q16_ONE : v;
  endfunction

  // effective configuration
  always_comb begin
    b0    = (reg_base != '0) ? reg_base : RW'(afrg_pkg::DEF_BASE);
    e_min = (reg_min != '0) ? reg_min : RW'(afrg_pkg::DEF_MIN);
    m0    = (reg_max != '0) ? reg_max : b0;
    e_max = (m0 < e_min) ? e_min : m0;
    b1    = (b0 < e_min) ? e_min : b0;
    e_base = (b1 > e_max) ? e_max : b1;
    e_qlim = (reg_qlim != '0) ? reg_qlim : afrg_pkg::DEF_QLIM;
    d0    = (reg_dec != '0) ? reg_dec : afrg_pkg::DEF_DEC;
    e_dec = (d0 < afrg_pkg::DEC_LO) ? afrg_pkg::DEC_LO :
            (d0 > afrg_pkg::DEC_HI) ? afrg_pkg::DEC_HI : d0;
    i0    = (reg_inc != '0) ? reg_inc : afrg_pkg::DEF_INC;
    e_inc = (i0 < afrg_pkg::INC_LO) ? afrg_pkg::INC_LO :
            (i0 > afrg_pkg::INC_HI) ? afrg_pkg::INC_HI : i0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_base <= RW'(afrg_pkg::DEF_BASE);
      reg_min  <= RW'(afrg_pkg::DEF_MIN);
      reg_max  <= RW'(afrg_pkg::DEF_BASE);
      reg_qlim <= afrg_pkg::DEF_QLIM;
      reg_llim <= '0;
      reg_dec  <= afrg_pkg::DEF_DEC;
      reg_inc  <= afrg_pkg::DEF_INC;
    end else if (cfg_valid) begin
      case (cfg_index)
        afrg_pkg::REG_BASE: reg_base <= cfg_data[RW-1:0];
        afrg_pkg::REG_MIN:  reg_min  <= cfg_data[RW-1:0];
        afrg_pkg::REG_MAX:  reg_max  <= cfg_data[RW-1:0];
        afrg_pkg::REG_QLIM: reg_qlim <= cfg_data[17:0];
        afrg_pkg::REG_LLIM: reg_llim <= cfg_data[19:0];
        afrg_pkg::REG_DEC:  reg_dec  <= cfg_data[15:0];
        afrg_pkg::REG_INC:  reg_inc  <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  // operands of the current pressure source
  always_comb begin
    case (src)
      3'd0: begin
        num  = lat[31] ? 32'd0 : lat;
        den  = {12'd0, reg_llim};
      end
      3'd1: begin
        num = {15'd0, qu};
        den = {14'd0, e_qlim};
      end
      3'd2: begin
        num = {15'd0, cu};
        den = afrg_pkg::CPU_LIM;
      end
      3'd3: begin
        num = {15'd0, gu};
        den = afrg_pkg::CPU_LIM;
      end
      3'd4: begin
        num = {15'd0, dr};
        den = afrg_pkg::DROP_LIM;
      end
      default: begin
        num = '0;
        den = 32'd1;
      end
    endcase
    skip = (num == '0) || (den == '0);
  end

  logic [31:0] fnum, fden, dnum, dden;
  always_comb begin
    fnum = {16'd0, e_dec};
    fden = (pmax < QW'(afrg_pkg::Q16_ONE)) ? 32'(afrg_pkg::Q16_ONE) : 32'(pmax);
    dnum = cmd.fac_go ? fnum : num;
    dden = cmd.fac_go ? fden : den;
  end

  // a source's division starts in the first cycle that src holds it;
  // a skipped source finishes at once through done_q
  assign div_start = cmd.fac_go || (init && !skip);

  afrg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (dnum),
    .den   (dden),
    .quo   (quo),
    .done  (div_done)
  );

  // saturate pressure to 4.0; pmax and over accumulate when a source's division ends
  assign pcur = (quo > QW'(afrg_pkg::Q16_MAXP)) ? QW'(afrg_pkg::Q16_MAXP) : quo;
  assign sts.div_done = div_done || done_q;

  logic cur_skip, fac_phase;
  always_ff @(posedge clk) begin
    if (rst) begin
      init      <= 1'b0;
      done_q    <= 1'b0;
      cur_skip  <= 1'b0;
      fac_phase <= 1'b0;
    end else begin
      init   <= cmd.load || cmd.div_go;
      done_q <= init && skip;
      if (init) cur_skip <= skip;
      if (cmd.fac_go) fac_phase <= 1'b1;
      else if (cmd.mul) fac_phase <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lat  <= latency;
      qu   <= sat1(queue_fill);
      cu   <= sat1(cpu_load);
      gu   <= sat1(gpu_load);
      dr   <= sat1(drop_rate);
      pmax <= '0;
      over <= 1'b0;
    end else if (div_done && !fac_phase && !cur_skip) begin
      if (pcur > pmax) pmax <= pcur;
      if (num > den) over <= 1'b1;
    end
    if (div_done && fac_phase) begin
      factor <= (quo < QW'(afrg_pkg::Q16_QUARTER)) ? afrg_pkg::Q16_QUARTER
                                                   : quo[16:0];
    end
  end

  // rate update: at most one multiply, then a clamp registered into rate_new
  always_comb begin
    if (over) begin
      prod = (RW+18)'(rate) * (RW+18)'(factor);
      r1   = (RW+1)'(prod >> 16);
    end else if (rate < e_base) begin
      prod = (RW+18)'(rate) * (RW+18)'(e_inc);
      r1   = (RW+1)'(prod >> 16);
      if (r1 > (RW+1)'(e_base)) r1 = (RW+1)'(e_base);
    end else begin
      prod = '0;
      r1   = (RW+1)'(rate);
    end
    r2 = (r1 < (RW+1)'(e_min)) ? e_min :
         (r1 > (RW+1)'(e_max)) ? e_max : r1[RW-1:0];
  end

  // reset settings give an effective base equal to the default base
  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= RW'(afrg_pkg::DEF_BASE);
    end else if (cmd.commit) begin
      rate <= rate_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) rate_new <= r2;
    if (cmd.commit) begin
      target_fps <= rate_new;
      overloaded <= over;
    end
  end

endmodule

// File: src/adaptive_frame_rate_governor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_frame_rate_governor_top
// Frame rate governor: one new target rate per feedback item.
// ----------------------------------------------------------------------------
// One item is processed at a time. Each of the five pressure sources is
// divided by its limit on a shared 48-step restoring divider (skipped when
// the value or its limit is zero), then come the factor division, a multiply
// state and a result state. The next item is accepted no earlier than the
// cycle after the result is taken. The rate starts at the effective base of
// the reset settings; register writes affect later updates and never reload
// the rate.
module adaptive_frame_rate_governor_top #(
  parameter int RATE_WIDTH = 18
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [31:0]    latency,
  input  logic [16:0]           queue_fill,
  input  logic [16:0]           cpu_load,
  input  logic [16:0]           gpu_load,
  input  logic [16:0]           drop_rate,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [RATE_WIDTH-1:0] target_fps,
  output logic                  overloaded,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data
);

  afrg_pkg::afrg_cmd_t cmd;
  afrg_pkg::afrg_sts_t sts;
  logic [2:0]          src;

  assign cfg_ready = 1'b1;

  afrg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .src       (src),
    .sts       (sts)
  );

  afrg_dp #(.RATE_WIDTH(RATE_WIDTH)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .src         (src),
    .sts         (sts),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .latency     (latency),
    .queue_fill  (queue_fill),
    .cpu_load    (cpu_load),
    .gpu_load    (gpu_load),
    .drop_rate   (drop_rate),
    .target_fps  (target_fps),
    .overloaded  (overloaded)
  );

endmodule
